FILE: hw/rtl/srde_pkg.sv
// ----------------------------------------------------------------------------
// srde_pkg: shared types and constants of the signed radix digit emitter
// Word field widths, action codes, special characters, sequencer states
// and the small control/status bundles passed between the blocks.
// ----------------------------------------------------------------------------
`default_nettype none

package srde_pkg;

  // Word field widths
  localparam int ACT_W   = 2;
  localparam int CHAR_W  = 8;
  localparam int NUM_W   = 32;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_CLEAR   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_APPEND  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CONVERT = 2'd2;

  // Characters that may not appear in an alphabet, and the sign character
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

  // Digit stack: a 32-bit magnitude never has more than 32 digits
  localparam int STACK_DEPTH = 32;
  localparam int STACK_AW    = 5;

  // Divider retires this many quotient bits per cycle
  localparam int DIV_STEP_BITS = 4;
  localparam int DIV_ROUNDS    = NUM_W / DIV_STEP_BITS;
  localparam int DIV_CNT_W     = $clog2(DIV_ROUNDS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_SIGN,
    S_RD,
    S_LOOK,
    S_SHOW
  } state_t;

  typedef struct packed {
    logic clear;
    logic append;
  } alpha_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/srde_if.sv
// ----------------------------------------------------------------------------
// srde_if: valid/ready channels of the signed radix digit emitter
// srde_in_if carries command words, srde_out_if carries character words.
// ----------------------------------------------------------------------------
`default_nettype none

interface srde_in_if;
  import srde_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [ACT_W-1:0]         action;
  logic [CHAR_W-1:0]        base_char;
  logic signed [NUM_W-1:0]  number;

  modport source (output valid, output action, output base_char, output number,
                  input ready);
  modport sink   (input valid, input action, input base_char, input number,
                  output ready);
endinterface

interface srde_out_if;
  import srde_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] out_char;
  logic              last;

  modport source (output valid, output out_char, output last, input ready);
  modport sink   (input valid, input out_char, input last, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/srde_div.sv
// ----------------------------------------------------------------------------
// srde_div: shared iterative divider
// Restoring division of a 32-bit magnitude by the alphabet length,
// DIV_STEP_BITS quotient bits per cycle. Quotient and remainder are held
// after done until the next start.
// ----------------------------------------------------------------------------
`default_nettype none

module srde_div #(
  parameter int DIVISOR_W = 7
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [srde_pkg::NUM_W-1:0]     dividend,
  input  logic [DIVISOR_W-1:0]           divisor,
  output srde_pkg::div_stat_t            stat,
  output logic [srde_pkg::NUM_W-1:0]     quotient,
  output logic [DIVISOR_W-1:0]           remainder
);
  import srde_pkg::*;

  logic                  busy;
  logic                  done;
  logic [DIV_CNT_W-1:0]  cnt;
  logic [DIVISOR_W-1:0]  dvs;
  logic [NUM_W-1:0]      q;
  logic [DIVISOR_W-1:0]  r;
  logic [NUM_W-1:0]      q_next;
  logic [DIVISOR_W-1:0]  r_next;

  // DIV_STEP_BITS restoring steps per cycle; remainder stays below the divisor
  always_comb begin
    logic [DIVISOR_W:0] sh;
    logic               qb;
    q_next = q;
    r_next = r;
    for (int i = 0; i < DIV_STEP_BITS; i++) begin
      sh = {r_next, q_next[NUM_W-1]};
      if (sh >= {1'b0, dvs}) begin
        r_next = DIVISOR_W'(sh - {1'b0, dvs});
        qb     = 1'b1;
      end else begin
        r_next = sh[DIVISOR_W-1:0];
        qb     = 1'b0;
      end
      q_next = {q_next[NUM_W-2:0], qb};
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == DIV_CNT_W'(DIV_ROUNDS - 1));
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_ROUNDS - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      q   <= dividend;
      r   <= '0;
      dvs <= divisor;
    end else if (busy) begin
      q <= q_next;
      r <= r_next;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = q;
  assign remainder = r;

endmodule

`default_nettype wire

FILE: hw/rtl/srde_alpha.sv
// ----------------------------------------------------------------------------
// srde_alpha: alphabet store and validity check
// Holds the loaded digit characters, a 256-bit seen map, the length
// (saturating at MAX_BASE + 1) and the bad flag. Registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module srde_alpha #(
  parameter int MAX_BASE = 64,
  parameter int LW       = 7,
  parameter int DW       = 6
) (
  input  logic                          clk,
  input  logic                          rst,
  input  srde_pkg::alpha_cmd_t          cmd,
  input  logic [srde_pkg::CHAR_W-1:0]   ch,
  input  logic                          rd_en,
  input  logic [DW-1:0]                 rd_addr,
  output logic [srde_pkg::CHAR_W-1:0]   rd_data,
  output logic [LW-1:0]                 length,
  output logic                          bad
);
  import srde_pkg::*;

  logic [CHAR_W-1:0]     alpha_mem [MAX_BASE];
  logic [2**CHAR_W-1:0]  seen;
  logic                  has_room;
  logic                  reject;

  assign has_room = (length < LW'(MAX_BASE));
  assign reject   = (ch == CH_NUL) || (ch == CH_PLUS) || (ch == CH_MINUS) ||
                    seen[ch] || !has_room;

  // Length, bad flag and seen map
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      length <= '0;
      bad    <= 1'b0;
      seen   <= '0;
    end else if (cmd.append) begin
      seen[ch] <= 1'b1;
      if (reject) begin
        bad <= 1'b1;
      end
      if (has_room) begin
        length <= length + 1'b1;
      end else begin
        length <= LW'(MAX_BASE + 1);
      end
    end
  end

  // Character memory
  always_ff @(posedge clk) begin
    if (cmd.append && has_room) begin
      alpha_mem[length[DW-1:0]] <= ch;
    end
    if (rd_en) begin
      rd_data <= alpha_mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/signed_radix_digit_emitter_core.sv
// Clear and append words update the alphabet when they are accepted.
// A convert runs the shared divider once per digit, restarting it on each
// nonzero quotient; then a '-' is loaded for a negative number, and each
// digit takes a stack read, an alphabet read and an output load.
// Input is taken one word at a time, only while the sequencer is idle.
// Reset (rst, synchronous) empties the alphabet; no output word is pending.
// ----------------------------------------------------------------------------
// signed_radix_digit_emitter_core: signed integer to text in a loaded radix
// Words either clear the alphabet, append a digit character, or convert a
// signed 32-bit number into an optional '-' and its digits, MSB first.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_radix_digit_emitter_core #(
  parameter int MAX_BASE = 64
) (
  input  logic       clk,
  input  logic       rst,
  srde_in_if.sink    in_ch,
  srde_out_if.source out_ch
);
  import srde_pkg::*;

  localparam int LW = $clog2(MAX_BASE + 2);
  localparam int DW = $clog2(MAX_BASE);
  localparam int BW = $clog2(MAX_BASE + 1);

  state_t               state, state_next;
  logic [STACK_AW:0]    depth, depth_next;
  logic                 neg;
  logic [CHAR_W-1:0]    out_char_r, out_char_next;
  logic                 last_r, last_next;
  logic                 out_valid;
  logic                 out_load;
  logic                 out_free;

  logic                 accept;
  logic                 conv_go;
  logic [NUM_W-1:0]     num_u;
  logic [NUM_W-1:0]     mag;

  alpha_cmd_t           acmd;
  logic [CHAR_W-1:0]    alpha_char;
  logic [LW-1:0]        alpha_len;
  logic                 alpha_bad;
  logic                 alpha_rd_en;

  div_stat_t            dstat;
  logic                 div_start;
  logic [NUM_W-1:0]     div_dividend;
  logic [NUM_W-1:0]     div_q;
  logic [BW-1:0]        div_r;
  logic                 push;

  logic [DW-1:0]        stack_mem [STACK_DEPTH];
  logic [DW-1:0]        stack_rd;
  logic                 stack_rd_en;
  logic [STACK_AW:0]    depth_m1;

  // Input decode
  assign in_ch.ready = (state == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign acmd.clear  = accept && (in_ch.action == ACT_CLEAR);
  assign acmd.append = accept && (in_ch.action == ACT_APPEND);
  assign conv_go     = accept && (in_ch.action == ACT_CONVERT) && !alpha_bad &&
                       (alpha_len >= LW'(2));

  // Magnitude; the most negative value maps onto 2^31 unsigned
  assign num_u = in_ch.number;
  assign mag   = num_u[NUM_W-1] ? (~num_u + 1'b1) : num_u;

  // Divider feed: first the magnitude, then each quotient until it is zero
  assign push         = (state == S_DIV) && dstat.done;
  assign div_start    = conv_go || (push && (div_q != '0));
  assign div_dividend = (state == S_IDLE) ? mag : div_q;

  assign out_free = !out_valid || out_ch.ready;
  assign depth_m1 = depth - 1'b1;

  srde_alpha #(
    .MAX_BASE (MAX_BASE),
    .LW       (LW),
    .DW       (DW)
  ) u_alpha (
    .clk     (clk),
    .rst     (rst),
    .cmd     (acmd),
    .ch      (in_ch.base_char),
    .rd_en   (alpha_rd_en),
    .rd_addr (stack_rd),
    .rd_data (alpha_char),
    .length  (alpha_len),
    .bad     (alpha_bad)
  );

  srde_div #(
    .DIVISOR_W (BW)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (alpha_len[BW-1:0]),
    .stat      (dstat),
    .quotient  (div_q),
    .remainder (div_r)
  );

  // Sequencer
  always_comb begin
    state_next    = state;
    depth_next    = depth;
    out_load      = 1'b0;
    out_char_next = out_char_r;
    last_next     = last_r;
    stack_rd_en   = 1'b0;
    alpha_rd_en   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (conv_go) begin
          state_next = S_DIV;
          depth_next = '0;
        end
      end
      S_DIV: begin
        if (dstat.done) begin
          depth_next = depth + 1'b1;
          if (div_q == '0) begin
            state_next = neg ? S_SIGN : S_RD;
          end
        end
      end
      S_SIGN: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_char_next = CH_MINUS;
          last_next     = 1'b0;
          state_next    = S_RD;
        end
      end
      S_RD: begin
        stack_rd_en = 1'b1;
        depth_next  = depth_m1;
        state_next  = S_LOOK;
      end
      S_LOOK: begin
        alpha_rd_en = 1'b1;
        state_next  = S_SHOW;
      end
      S_SHOW: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_char_next = alpha_char;
          last_next     = (depth == '0);
          state_next    = (depth == '0) ? S_IDLE : S_RD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      depth     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      depth <= depth_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (conv_go) begin
      neg <= num_u[NUM_W-1];
    end
    out_char_r <= out_char_next;
    last_r     <= last_next;
  end

  // Digit stack, least significant digit pushed first
  always_ff @(posedge clk) begin
    if (push) begin
      stack_mem[depth[STACK_AW-1:0]] <= div_r[DW-1:0];
    end
    if (stack_rd_en) begin
      stack_rd <= stack_mem[depth_m1[STACK_AW-1:0]];
    end
  end

  assign out_ch.valid    = out_valid;
  assign out_ch.out_char = out_char_r;
  assign out_ch.last     = last_r;

endmodule

`default_nettype wire
